@@ hdl/sqser_pkg.sv @@
`timescale 1ns / 1ps

package sqser_pkg;

  localparam int unsigned FRAC_BITS      = 30;
  localparam int unsigned X_W            = 31;
  localparam int unsigned TOL_W          = 30;
  localparam int unsigned TERM_W         = 30;
  localparam int unsigned ACC_W          = 31;
  localparam int unsigned SUM_W          = 33;
  localparam int unsigned ROOT_W         = 31;
  localparam int unsigned USED_W         = 9;
  localparam int unsigned STEP_W         = 5;
  localparam int unsigned MAX_TERMS_DEF  = 256;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1074);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_X,
    ST_PREP_M,
    ST_MUL_M,
    ST_PREP_D,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

@@ hdl/sqrt_one_plus_x_series.sv @@
`timescale 1ns / 1ps
// Channel   | Ports                                        | Handshake
// ----------+----------------------------------------------+------------------------------
// command   | start, busy, x_value                         | taken when start & !busy
// result    | done, approx_root, terms_used, limit_hit     | one-cycle strobe on done
// config    | tolerance_valid, tolerance_ready, tolerance  | written when valid & ready
//
// Each series term runs, in order, a bit-serial multiply by x, a bit-serial multiply by
// (2i-1) and a restoring divide by 2(i+1); the two multiplies share one shift-add unit,
// and the divide uses its own subtractor on the same shift register.
// busy stays high until done has pulsed.
// Reset is synchronous and sets tolerance to 1074; the receiver cannot stall results.

module sqrt_one_plus_x_series #(
  parameter int unsigned MAX_TERMS = sqser_pkg::MAX_TERMS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [sqser_pkg::X_W-1:0]   x_value,
  output logic                               done,
  output logic        [sqser_pkg::ROOT_W-1:0] approx_root,
  output logic        [sqser_pkg::USED_W-1:0] terms_used,
  output logic                               limit_hit,
  input  logic                               tolerance_valid,
  output logic                               tolerance_ready,
  input  logic        [sqser_pkg::TOL_W-1:0] tolerance
);

  localparam int unsigned CW      = $clog2(MAX_TERMS + 1);
  localparam int unsigned MW      = CW + 1;
  localparam int unsigned DVW     = CW + 2;
  localparam int unsigned PROD_W  = sqser_pkg::ACC_W + sqser_pkg::X_W;
  localparam int unsigned CNT_EXT = (CW > sqser_pkg::USED_W) ? CW : sqser_pkg::USED_W;

  sqser_pkg::state_t state, state_next;

  logic [sqser_pkg::TOL_W-1:0]  tol;
  logic                         x_neg;
  logic [sqser_pkg::X_W-1:0]    x_mag;
  logic                         t_neg;
  logic [sqser_pkg::TERM_W-1:0] t_mag;
  logic signed [sqser_pkg::SUM_W-1:0] sum;
  logic [CW-1:0]                count;
  logic                         limit;
  logic [sqser_pkg::ACC_W-1:0]  acc;
  logic [sqser_pkg::X_W-1:0]    sh;
  logic [DVW-1:0]               rem;
  logic [sqser_pkg::STEP_W-1:0] step;

  logic [sqser_pkg::ACC_W-1:0]  add_sum;
  logic [PROD_W-1:0]            prod;
  logic [MW-1:0]                mult_m;
  logic [DVW-1:0]               divisor;
  logic [DVW:0]                 rem_shift;
  logic                         q_bit;
  logic                         term_live;
  logic                         cap_reached;
  logic                         step_last;
  logic [CNT_EXT-1:0]           count_ext;

  assign tolerance_ready = 1'b1;
  assign busy            = (state != sqser_pkg::ST_IDLE);

  assign add_sum   = acc + (sh[0] ? {1'b0, t_mag} : '0);
  assign prod      = {acc, sh};
  assign mult_m    = {count, 1'b0} - MW'(1);
  assign divisor   = {(CW + 1)'(count) + (CW + 1)'(1), 1'b0};
  assign rem_shift = {rem, sh[sqser_pkg::TERM_W-1]};
  assign q_bit     = (rem_shift >= {1'b0, divisor});
  assign term_live   = (t_mag > tol);
  assign cap_reached = (count >= CW'(MAX_TERMS));

  always_comb begin
    case (state)
      sqser_pkg::ST_MUL_X: step_last = (step == sqser_pkg::STEP_W'(sqser_pkg::X_W - 1));
      sqser_pkg::ST_MUL_M: step_last = (step == sqser_pkg::STEP_W'(MW - 1));
      sqser_pkg::ST_DIV:   step_last = (step == sqser_pkg::STEP_W'(sqser_pkg::TERM_W - 1));
      default:             step_last = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sqser_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      sqser_pkg::ST_IDLE: begin
        if (start) state_next = sqser_pkg::ST_CHECK;
      end
      sqser_pkg::ST_CHECK: begin
        if (term_live && !cap_reached) state_next = sqser_pkg::ST_MUL_X;
        else                           state_next = sqser_pkg::ST_DONE;
      end
      sqser_pkg::ST_MUL_X: begin
        if (step_last) state_next = sqser_pkg::ST_PREP_M;
      end
      sqser_pkg::ST_PREP_M: state_next = sqser_pkg::ST_MUL_M;
      sqser_pkg::ST_MUL_M: begin
        if (step_last) state_next = sqser_pkg::ST_PREP_D;
      end
      sqser_pkg::ST_PREP_D: state_next = sqser_pkg::ST_DIV;
      sqser_pkg::ST_DIV: begin
        if (step_last) state_next = sqser_pkg::ST_CHECK;
      end
      sqser_pkg::ST_DONE: begin
        done       = 1'b1;
        state_next = sqser_pkg::ST_IDLE;
      end
      default: state_next = sqser_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= sqser_pkg::TOL_RESET;
    end else if (tolerance_valid && tolerance_ready) begin
      tol <= tolerance;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      sqser_pkg::ST_IDLE: begin
        if (start) begin
          x_neg <= x_value[sqser_pkg::X_W-1];
          x_mag <= x_value[sqser_pkg::X_W-1] ? (sqser_pkg::X_W'(0) - x_value) : x_value;
          t_neg <= x_value[sqser_pkg::X_W-1];
          t_mag <= sqser_pkg::TERM_W'((x_value[sqser_pkg::X_W-1] ?
                     (sqser_pkg::X_W'(0) - x_value) : x_value) >> 1);
          sum   <= sqser_pkg::SUM_W'(64'd1 << sqser_pkg::FRAC_BITS);
          count <= '0;
          limit <= 1'b0;
        end
      end
      sqser_pkg::ST_CHECK: begin
        if (term_live) begin
          if (cap_reached) begin
            limit <= 1'b1;
          end else begin
            sum   <= t_neg ? sum - $signed(sqser_pkg::SUM_W'(t_mag))
                           : sum + $signed(sqser_pkg::SUM_W'(t_mag));
            count <= count + CW'(1);
            t_neg <= !(t_neg ^ x_neg);
            acc   <= '0;
            sh    <= x_mag;
            step  <= '0;
          end
        end
      end
      sqser_pkg::ST_MUL_X, sqser_pkg::ST_MUL_M: begin
        acc  <= {1'b0, add_sum[sqser_pkg::ACC_W-1:1]};
        sh   <= {add_sum[0], sh[sqser_pkg::X_W-1:1]};
        step <= step + sqser_pkg::STEP_W'(1);
      end
      sqser_pkg::ST_PREP_M: begin
        t_mag <= sqser_pkg::TERM_W'(prod >> sqser_pkg::FRAC_BITS);
        acc   <= '0;
        sh    <= sqser_pkg::X_W'(mult_m);
        step  <= '0;
      end
      sqser_pkg::ST_PREP_D: begin
        rem  <= DVW'(prod >> (PROD_W - 1 - MW));
        sh   <= sqser_pkg::X_W'(sqser_pkg::TERM_W'(prod >> (sqser_pkg::X_W - MW)));
        step <= '0;
      end
      sqser_pkg::ST_DIV: begin
        rem  <= q_bit ? DVW'(rem_shift - {1'b0, divisor}) : DVW'(rem_shift);
        sh   <= {sh[sqser_pkg::TERM_W-1:0], q_bit};
        step <= step + sqser_pkg::STEP_W'(1);
        if (step_last) begin
          t_mag <= {sh[sqser_pkg::TERM_W-2:0], q_bit};
        end
      end
      default: begin
      end
    endcase
  end

  assign count_ext = CNT_EXT'(count);

  always_comb begin
    if (sum < 0) begin
      approx_root = '0;
    end else if (sum > $signed(sqser_pkg::SUM_W'({sqser_pkg::ROOT_W{1'b1}}))) begin
      approx_root = '1;
    end else begin
      approx_root = sum[sqser_pkg::ROOT_W-1:0];
    end
    if (count_ext > CNT_EXT'({sqser_pkg::USED_W{1'b1}})) begin
      terms_used = '1;
    end else begin
      terms_used = count_ext[sqser_pkg::USED_W-1:0];
    end
    limit_hit = limit;
  end

endmodule

@@ bench/tb_sqrt_one_plus_x_series.sv @@
`timescale 1ns / 1ps

module tb_sqrt_one_plus_x_series;

  localparam int unsigned SERIES_CAP      = sqser_pkg::MAX_TERMS_DEF;
  localparam int unsigned WATCHDOG_LIMIT  = 100000;
  localparam int unsigned DRAIN_CYCLES    = 200;
  localparam int unsigned N_PHASES        = 6;
  localparam int unsigned ITEMS_PER_PHASE = 170;
  localparam int unsigned N_DIRECTED      = 24;
  localparam int unsigned REPORT_LIMIT    = 10;

  localparam logic [sqser_pkg::TOL_W-1:0]  TOL_MAX = '1;
  localparam logic [sqser_pkg::ROOT_W-1:0] ONE_Q   = 31'h4000_0000;

  typedef struct packed {
    logic [sqser_pkg::ROOT_W-1:0] root;
    logic [sqser_pkg::USED_W-1:0] used;
    logic                         limit;
  } root_result_t;

  typedef struct packed {
    logic [sqser_pkg::TOL_W-1:0]      tol;
    logic signed [sqser_pkg::X_W-1:0] x;
    logic                             known;
    root_result_t                     want;
  } series_vector_t;

  localparam root_result_t NO_RESULT = '0;
  localparam root_result_t ONE_ROOT  = '{ONE_Q, 9'd0, 1'b0};

  localparam series_vector_t DIRECTED [N_DIRECTED] = '{
    '{sqser_pkg::TOL_RESET, 31'sd0,        1'b1, ONE_ROOT},
    '{sqser_pkg::TOL_RESET, 31'sd1,        1'b1, ONE_ROOT},
    '{sqser_pkg::TOL_RESET, -31'sd1,       1'b1, ONE_ROOT},
    '{sqser_pkg::TOL_RESET, 31'sd2,        1'b1, ONE_ROOT},
    '{sqser_pkg::TOL_RESET, 31'sd2148,     1'b1, ONE_ROOT},
    '{sqser_pkg::TOL_RESET, 31'sd2150,     1'b0, NO_RESULT},
    '{sqser_pkg::TOL_RESET, -31'sd2150,    1'b0, NO_RESULT},
    '{sqser_pkg::TOL_RESET, 31'h3FFF_FFFF, 1'b0, NO_RESULT},
    '{sqser_pkg::TOL_RESET, 31'h4000_0000, 1'b0, NO_RESULT},
    '{sqser_pkg::TOL_RESET, 31'h4000_0001, 1'b0, NO_RESULT},
    '{sqser_pkg::TOL_RESET, 31'h1000_0000, 1'b0, NO_RESULT},
    '{sqser_pkg::TOL_RESET, 31'h6000_0000, 1'b0, NO_RESULT},
    '{sqser_pkg::TOL_RESET, 31'h2AAA_AAAA, 1'b0, NO_RESULT},
    '{30'd0,                31'sd0,        1'b1, ONE_ROOT},
    '{30'd0,                31'sd1,        1'b1, ONE_ROOT},
    '{30'd0,                31'sd2,        1'b0, NO_RESULT},
    '{30'd0,                31'h0040_0000, 1'b0, NO_RESULT},
    '{30'd0,                31'h7FC0_0000, 1'b0, NO_RESULT},
    '{30'd0,                31'h4000_0000, 1'b0, NO_RESULT},
    '{30'd1,                31'h3FFF_FFFF, 1'b0, NO_RESULT},
    '{TOL_MAX,              31'h3FFF_FFFF, 1'b1, ONE_ROOT},
    '{TOL_MAX,              31'h4000_0000, 1'b1, ONE_ROOT},
    '{TOL_MAX,              31'h1555_5555, 1'b1, ONE_ROOT},
    '{sqser_pkg::TOL_RESET, 31'h0500_0000, 1'b0, NO_RESULT}
  };

  logic                             clk             = 1'b0;
  logic                             rst             = 1'b1;
  logic                             start           = 1'b0;
  logic signed [sqser_pkg::X_W-1:0] x_value         = '0;
  logic                             tolerance_valid = 1'b0;
  logic [sqser_pkg::TOL_W-1:0]      tolerance       = '0;
  logic                             busy;
  logic                             done;
  logic [sqser_pkg::ROOT_W-1:0]     approx_root;
  logic [sqser_pkg::USED_W-1:0]     terms_used;
  logic                             limit_hit;
  logic                             tolerance_ready;

  root_result_t                pending_roots[$];
  logic [sqser_pkg::TOL_W-1:0] tol_model    = sqser_pkg::TOL_RESET;
  int unsigned                 mismatches   = 0;
  int unsigned                 results_seen = 0;
  int unsigned                 capped_roots = 0;
  int unsigned                 args_sent    = 0;
  int unsigned                 tol_writes   = 0;
  int unsigned                 quiet_cycles = 0;

  sqrt_one_plus_x_series uut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .x_value         (x_value),
    .done            (done),
    .approx_root     (approx_root),
    .terms_used      (terms_used),
    .limit_hit       (limit_hit),
    .tolerance_valid (tolerance_valid),
    .tolerance_ready (tolerance_ready),
    .tolerance       (tolerance)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic root_result_t series_root(input logic [sqser_pkg::TOL_W-1:0] tol,
                                               input logic signed [sqser_pkg::X_W-1:0] xv);
    logic [sqser_pkg::X_W-1:0] x_abs;
    logic [63:0]               x_mag;
    logic [63:0]               t_mag;
    logic [63:0]               prod;
    logic [63:0]               n;
    longint                    acc;
    logic                      x_neg;
    logic                      t_neg;
    root_result_t              r;
    x_neg = xv[sqser_pkg::X_W-1];
    x_abs = x_neg ? sqser_pkg::X_W'(-xv) : xv;
    x_mag = 64'(x_abs);
    t_neg = x_neg;
    t_mag = x_mag >> 1;
    acc   = longint'(64'd1 << sqser_pkg::FRAC_BITS);
    n     = 0;
    r     = '0;
    while (t_mag > 64'(tol)) begin
      if (n >= SERIES_CAP) begin
        r.limit = 1'b1;
        break;
      end
      acc   = t_neg ? acc - longint'(t_mag) : acc + longint'(t_mag);
      n++;
      // next term: -term * x * (2n-1) / (2(n+1)), truncated at each step
      prod  = (t_mag * x_mag) >> sqser_pkg::FRAC_BITS;
      t_mag = (prod * (2 * n - 1)) / (2 * (n + 1));
      t_neg = ~(t_neg ^ x_neg);
    end
    if (acc < 0) r.root = '0;
    else if (acc > 64'sh7FFF_FFFF) r.root = '1;
    else r.root = sqser_pkg::ROOT_W'(acc);
    r.used = (n > 511) ? '1 : sqser_pkg::USED_W'(n);
    return r;
  endfunction

  // mostly small arguments; wide and near-unity ones are slow and kept rare
  function automatic logic signed [sqser_pkg::X_W-1:0] pick_x();
    int unsigned               sel;
    logic [sqser_pkg::X_W-1:0] mag;
    sel = $urandom_range(99);
    if (sel < 85) mag = sqser_pkg::X_W'($urandom_range(0, 1 << 26));
    else if (sel < 97) return sqser_pkg::X_W'($urandom);
    else mag = sqser_pkg::X_W'(32'h4000_0000 - $urandom_range(0, 4095));
    return $urandom_range(1) ? sqser_pkg::X_W'(-mag) : mag;
  endfunction

  task automatic send_x(input logic signed [sqser_pkg::X_W-1:0] xv, input logic known,
                        input root_result_t want);
    start   <= 1'b1;
    x_value <= xv;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_roots.push_back(known ? want : series_root(tol_model, xv));
    args_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
  endtask

  task automatic write_tol(input logic [sqser_pkg::TOL_W-1:0] v);
    tolerance_valid <= 1'b1;
    tolerance       <= v;
    @(posedge clk);
    while (!tolerance_ready) @(posedge clk);
    tolerance_valid <= 1'b0;
    tol_model = v;
    tol_writes++;
  endtask

  task automatic note_mismatch(input string what, input root_result_t want,
                               input root_result_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%s at %0t: expected root %h used %0d limit %0d, %s %h used %0d limit %0d",
               what, $time, want.root, want.used, want.limit, "got root",
               got.root, got.used, got.limit);
  endtask

  always @(posedge clk) begin
    root_result_t want;
    root_result_t got;
    if ((start && !busy) || (tolerance_valid && tolerance_ready) || done) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else if (!rst && done) begin
      got = '{approx_root, terms_used, limit_hit};
      results_seen++;
      if (limit_hit) capped_roots++;
      if (pending_roots.size() == 0) begin
        note_mismatch("unexpected result", NO_RESULT, got);
      end else begin
        want = pending_roots.pop_front();
        if (got.root !== want.root || got.used !== want.used || got.limit !== want.limit)
          note_mismatch("mismatch", want, got);
      end
    end
  end

  initial begin
    logic [sqser_pkg::TOL_W-1:0] phase_tol;
    bit                          steady;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].tol != tol_model) begin
        drain();
        write_tol(DIRECTED[i].tol);
      end
      send_x(DIRECTED[i].x, DIRECTED[i].known, DIRECTED[i].want);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       phase_tol = sqser_pkg::TOL_RESET;
        1:       phase_tol = sqser_pkg::TOL_W'($urandom_range(1, 1 << 20));
        2:       phase_tol = TOL_MAX;
        3:       phase_tol = '0;
        4:       phase_tol = sqser_pkg::TOL_W'(1);
        default: phase_tol = sqser_pkg::TOL_W'($urandom_range(1, TOL_MAX));
      endcase
      drain();
      write_tol(phase_tol);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // hold a steady stream through part of the run
        steady = (args_sent >= 300 && args_sent < 450);
        if (!steady && $urandom_range(99) < 2) begin
          drain();
        end else if (!steady && $urandom_range(99) < 20) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 40)) @(posedge clk);
        end
        send_x(pick_x(), 1'b0, NO_RESULT);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += pending_roots.size();

    $display("swept %0d arguments across %0d tolerance writes, including both extremes",
             args_sent, tol_writes);
    $display("checked %0d roots, %0d of them stopped at the term cap",
             results_seen, capped_roots);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
